@@ sv/baseline_mean_subtract_assert.svh @@
// Assertion macros for the baseline mean subtraction checker.
// No dependencies; included by the checker file only.
`ifndef BASELINE_MEAN_SUBTRACT_ASSERT_SVH
`define BASELINE_MEAN_SUBTRACT_ASSERT_SVH

// consequent checked in the same cycle
`define BMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bms_pkg.sv @@
// Shared types and constants for the baseline mean subtraction block.
// No dependencies.
`default_nettype none

package bms_pkg;

    localparam int CFG_W = 6;

    typedef enum logic [1:0] {
        CMD_BASE  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_PASS  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      trace_end;
    } t_cmd_ctl;

endpackage

`default_nettype wire

@@ sv/bms_if.sv @@
// Channel interfaces: sample input, corrected output, configuration write.
// Depends on bms_pkg.
`default_nettype none

interface bms_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          trace_end;
    modport source (output valid, sample, trace_end, input ready);
    modport sink   (input valid, sample, trace_end, output ready);
endinterface

interface bms_out_if #(parameter int OUT_BITS = 17);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] corrected;
    logic                       last_out;
    modport source (output valid, corrected, last_out, input ready);
    modport sink   (input valid, corrected, last_out, output ready);
endinterface

interface bms_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bms_pkg::CFG_W-1:0]  base_count;
    modport source (output valid, base_count, input ready);
    modport sink   (input valid, base_count, output ready);
endinterface

`default_nettype wire

@@ sv/bms_front.sv @@
// Front end: holds base_count, counts baseline words and classifies each word.
// Depends on bms_pkg.
`default_nettype none

module bms_front #(
    parameter int MAX_BASE = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [bms_pkg::CFG_W-1:0] i_cfg_base_count,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_trace_end,
    input  logic                      i_q_full,
    output logic                      o_push,
    output bms_pkg::t_cmd_ctl         o_ctl
);
    import bms_pkg::*;

    localparam int CNT_W = $clog2(MAX_BASE + 1);
    localparam int EXT_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic [CFG_W-1:0] r_base_count, n_base_count;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic             r_mean_ready, n_mean_ready;

    logic [EXT_W-1:0] w_base_ext;
    logic [EXT_W-1:0] w_eff;
    logic [EXT_W-1:0] w_seen_inc;
    logic             w_close;

    assign w_base_ext = EXT_W'(r_base_count);
    assign w_seen_inc = EXT_W'(r_seen) + EXT_W'(1);

    always_comb begin
        priority if (w_base_ext == '0) begin
            w_eff = EXT_W'(1);
        end else if (w_base_ext > EXT_W'(MAX_BASE)) begin
            w_eff = EXT_W'(MAX_BASE);
        end else begin
            w_eff = w_base_ext;
        end
    end

    assign w_close = (w_seen_inc >= w_eff) || i_trace_end;

    assign o_ready         = !i_q_full;
    assign o_push          = i_valid && !i_q_full;
    assign o_ctl.trace_end = i_trace_end;
    assign o_ctl.kind      = r_mean_ready ? CMD_PASS : (w_close ? CMD_CLOSE : CMD_BASE);

    always_comb begin
        n_base_count = i_cfg_valid ? i_cfg_base_count : r_base_count;
        n_seen       = r_seen;
        n_mean_ready = r_mean_ready;
        if (o_push) begin
            if (r_mean_ready) begin
                if (i_trace_end) begin
                    n_mean_ready = 1'b0;
                end
            end else if (w_close) begin
                n_seen       = '0;
                n_mean_ready = !i_trace_end;
            end else begin
                n_seen = w_seen_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_count <= CFG_W'(1);
            r_seen       <= '0;
            r_mean_ready <= 1'b0;
        end else begin
            r_base_count <= n_base_count;
            r_seen       <= n_seen;
            r_mean_ready <= n_mean_ready;
        end
    end

endmodule

`default_nettype wire

@@ sv/bms_queue.sv @@
// Two-entry command queue between front end and back end.
// No package dependencies.
`default_nettype none

module bms_queue #(
    parameter int W = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

@@ sv/bms_back.sv @@
// Back end: baseline store, sum, serial rounding divider and output register.
// Depends on bms_pkg.
`default_nettype none

module bms_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_BASE    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  bms_pkg::t_cmd_ctl             i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS:0]   o_corrected,
    output logic                          o_last_out
);
    import bms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BASE + 1);
    localparam int AW     = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_DIV  = 5'b00100,
        S_RD   = 5'b01000,
        S_WR   = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic signed [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              r_idx;
    logic                          r_end;
    logic                          r_neg;
    logic [NUM_W-1:0]              r_num;
    logic [DEN_W-1:0]              r_rem;
    logic [STEP_W-1:0]             r_step;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic signed [SAMPLE_BITS-1:0] r_buf [MAX_BASE];
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS:0]   r_corr;
    logic                          r_last;

    logic                          w_free;
    logic                          w_store;
    logic                          w_load;
    logic                          w_idx_last;
    logic [SUM_W-1:0]              w_mag;
    logic [NUM_W-1:0]              w_num_init;
    logic [DEN_W-1:0]              w_den;
    logic [DEN_W:0]                w_trial;
    logic                          w_ge;
    logic [DEN_W:0]                w_diff_rem;
    logic [DEN_W-1:0]              w_rem_n;
    logic signed [SAMPLE_BITS-1:0] w_q;
    logic signed [SAMPLE_BITS:0]   w_sub_a;
    logic signed [SAMPLE_BITS:0]   w_diff;
    logic                          w_last;

    assign w_free     = !r_out_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty
                        && ((i_ctl.kind != CMD_PASS) || w_free);
    assign w_store    = o_pop && (i_ctl.kind != CMD_PASS);
    assign w_idx_last = (r_idx == (r_cnt - CNT_W'(1)));
    assign w_load     = (o_pop && (i_ctl.kind == CMD_PASS)) || ((r_state == S_WR) && w_free);

    // |sum| * 2 + n over 2n gives round to nearest, ties away from zero
    assign w_mag      = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_num_init = {w_mag, 1'b0} + NUM_W'(r_cnt);
    assign w_den      = {r_cnt, 1'b0};
    assign w_trial    = {r_rem, r_num[NUM_W-1]};
    assign w_ge       = (w_trial >= {1'b0, w_den});
    assign w_diff_rem = w_trial - {1'b0, w_den};
    assign w_rem_n    = w_ge ? w_diff_rem[DEN_W-1:0] : w_trial[DEN_W-1:0];
    assign w_q        = $signed(r_num[SAMPLE_BITS-1:0]);

    assign w_sub_a = (r_state == S_WR) ? (SAMPLE_BITS+1)'(r_rd_data)
                                       : (SAMPLE_BITS+1)'(i_sample);
    assign w_diff  = w_sub_a - (SAMPLE_BITS+1)'(r_mean);
    assign w_last  = (r_state == S_WR) ? (r_end && w_idx_last) : i_ctl.trace_end;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && (i_ctl.kind == CMD_CLOSE)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                if (w_free) begin
                    n_state = w_idx_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_buf[r_cnt[AW-1:0]] <= i_sample;
        end
        r_rd_data <= r_buf[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_store) begin
                r_sum <= r_sum + SUM_W'(i_sample);
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if ((r_state == S_WR) && w_free && w_idx_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_ctl.kind == CMD_CLOSE)) begin
            r_end <= i_ctl.trace_end;
        end
        unique case (r_state)
            S_LOAD: begin
                r_num  <= w_num_init;
                r_rem  <= '0;
                r_step <= '0;
                r_neg  <= r_sum[SUM_W-1];
                r_idx  <= '0;
            end
            S_DIV: begin
                r_num  <= {r_num[NUM_W-2:0], w_ge};
                r_rem  <= w_rem_n;
                r_step <= r_step + STEP_W'(1);
            end
            S_RD: begin
                r_mean <= r_neg ? -w_q : w_q;
            end
            S_WR: begin
                if (w_free && !w_idx_last) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_corr <= w_diff;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_corrected = r_corr;
    assign o_last_out  = r_last;

endmodule

`default_nettype wire

@@ sv/baseline_mean_subtract.sv @@
// Baseline mean subtraction, top level. Depends on bms_pkg, bms_if, front/queue/back.
// A word after the baseline passes through the command queue and the output register.
// Streaming: 1 word per cycle while the output is not back-pressured; closing the baseline
// runs a load state and the serial divider, then a read and a write state per buffered word.
// Synchronous active-low reset; base_count resets to 1, buffer contents are not cleared.
`default_nettype none

module baseline_mean_subtract #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_BASE    = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bms_cfg_if.sink  i_cfg,
    bms_in_if.sink   i_in,
    bms_out_if.source o_out
);
    import bms_pkg::*;

    localparam int QW = SAMPLE_BITS + $bits(t_cmd_ctl);

    logic                          w_push;
    logic                          w_pop;
    logic                          w_full;
    logic                          w_empty;
    t_cmd_ctl                      w_front_ctl;
    t_cmd_ctl                      w_q_ctl;
    logic [QW-1:0]                 w_q_data;
    logic signed [SAMPLE_BITS-1:0] w_q_sample;

    assign i_cfg.ready = 1'b1;

    bms_front #(
        .MAX_BASE (MAX_BASE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_base_count (i_cfg.base_count),
        .i_valid          (i_in.valid),
        .o_ready          (i_in.ready),
        .i_trace_end      (i_in.trace_end),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_ctl            (w_front_ctl)
    );

    bms_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_ctl, i_in.sample}),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_data  (w_q_data)
    );

    assign w_q_ctl    = w_q_data[QW-1:SAMPLE_BITS];
    assign w_q_sample = $signed(w_q_data[SAMPLE_BITS-1:0]);

    bms_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BASE    (MAX_BASE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_ctl       (w_q_ctl),
        .i_sample    (w_q_sample),
        .o_pop       (w_pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_corrected (o_out.corrected),
        .o_last_out  (o_out.last_out)
    );

endmodule

`default_nettype wire

@@ sv/bms_checker.sv @@
// Port-level checks for baseline_mean_subtract, attached by bind.
// Depends on baseline_mean_subtract_assert.svh.
`default_nettype none
`include "baseline_mean_subtract_assert.svh"

module bms_checker #(
    parameter int OUT_BITS = 17
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_cfg_valid,
    input wire logic                       i_cfg_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [OUT_BITS-1:0] i_out_corrected,
    input wire logic                       i_out_last
);
    localparam logic [OUT_BITS-1:0] MIN_CORR = {1'b1, {(OUT_BITS-1){1'b0}}};

    `BMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_corrected) && $stable(i_out_last), "stalled output word changed")
    `BMS_ASSERT_SAME(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid, "output valid straight after reset")
    `BMS_ASSERT_SAME(a_corr_range, i_clk, i_rst_n, i_out_valid, i_out_corrected != MIN_CORR, "corrected word out of range")
    `BMS_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready, "config write back-pressured")

endmodule

bind baseline_mean_subtract bms_checker #(
    .OUT_BITS (SAMPLE_BITS + 1)
) u_bms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg.valid),
    .i_cfg_ready     (i_cfg.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_corrected (o_out.corrected),
    .i_out_last      (o_out.last_out)
);

`default_nettype wire
